// ----- rtl/core/wcs_pkg.sv -----
// ----------------------------------------------------------------------------
// wcs_pkg
// shared types and codes of the waveform capture store with edge search
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int CMD_W    = 2;
  localparam int BIT_W    = 5;
  localparam int CODE_W   = 8;
  localparam int START_W  = 12;
  localparam int TTIME_W  = 13;
  localparam int BIU_W    = 6;

  // command codes on the request channel
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_COMPARE = 2'd2,
    CMD_RSVD    = 2'd3
  } wcs_cmd_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_DROP,
    OP_FIND,
    OP_COMPARE,
    OP_NOP
  } wcs_op_t;

  typedef struct packed {
    wcs_op_t             op;
    logic [BIT_W-1:0]    bit_index;
    logic [CODE_W-1:0]   sample_value;
    logic [START_W-1:0]  start_time;
  } wcs_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLANE,
    ST_ORIGIN,
    ST_SCAN,
    ST_CPLANE,
    ST_CPREV,
    ST_CCUR,
    ST_RESULT
  } wcs_state_t;

endpackage

// ----- rtl/core/wcs_if.sv -----
// ----------------------------------------------------------------------------
// wcs_if
// request and response channels of the capture store
// ----------------------------------------------------------------------------
interface wcs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  bit_index;
  logic [7:0]  sample_value;
  logic [11:0] start_time;

  modport source (output valid, output command, output bit_index,
                  output sample_value, output start_time, input ready);
  modport sink   (input valid, input command, input bit_index,
                  input sample_value, input start_time, output ready);
endinterface

interface wcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [12:0] transition_time;
  logic        no_transition;
  logic        differs;
  logic        full_drop;

  modport source (output valid, output transition_time, output no_transition,
                  output differs, output full_drop, input ready);
  modport sink   (input valid, input transition_time, input no_transition,
                  input differs, input full_drop, output ready);
endinterface

// ----- rtl/core/wcs_front.sv -----
// ----------------------------------------------------------------------------
// wcs_front
// accepts request beats and classifies them into queue entries
// ----------------------------------------------------------------------------
module wcs_front #(
  parameter int MAX_BITS = 32
) (
  wcs_req_if.sink              req,
  input  logic                 q_full,
  output logic                 push,
  output wcs_pkg::wcs_entry_t  entry
);
  import wcs_pkg::*;

  logic bit_out_of_range;

  assign bit_out_of_range = 7'(req.bit_index) >= 7'(MAX_BITS);

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    entry.bit_index    = req.bit_index;
    entry.sample_value = req.sample_value;
    entry.start_time   = req.start_time;
    unique case (wcs_cmd_t'(req.command))
      CMD_APPEND:  entry.op = bit_out_of_range ? OP_DROP : OP_APPEND;
      CMD_FIND:    entry.op = OP_FIND;
      // compare at time zero never differs
      CMD_COMPARE: entry.op = (req.start_time == '0) ? OP_NOP : OP_COMPARE;
      default:     entry.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/core/wcs_queue.sv -----
// ----------------------------------------------------------------------------
// wcs_queue
// two-entry queue between the classifying front and the executing back
// ----------------------------------------------------------------------------
module wcs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wcs_pkg::wcs_entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output wcs_pkg::wcs_entry_t  head
);
  import wcs_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wcs_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/wcs_back.sv -----
// ----------------------------------------------------------------------------
// wcs_back
// executes appends, plane walks for edge search and previous-sample compare
// ----------------------------------------------------------------------------
module wcs_back #(
  parameter int MAX_BITS    = 32,
  parameter int PLANE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [5:0]           bits_in_use,
  input  logic                 q_valid,
  input  wcs_pkg::wcs_entry_t  head,
  output logic                 pop,
  wcs_rsp_if.source            rsp
);
  import wcs_pkg::*;

  localparam int CW    = $clog2(PLANE_DEPTH + 1);
  localparam int DW    = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
  localparam int PIW   = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int PCW   = $clog2(MAX_BITS + 1);
  localparam int AW    = $clog2(MAX_BITS * PLANE_DEPTH);
  localparam int TW    = (CW > START_W) ? CW : START_W;
  localparam int WORDS = MAX_BITS * PLANE_DEPTH;

  function automatic logic [AW-1:0] addr_of(input logic [PIW-1:0] plane,
                                            input logic [DW-1:0] pos);
    addr_of = AW'(plane) * AW'(PLANE_DEPTH) + AW'(pos);
  endfunction

  wcs_state_t state, state_next;

  logic [CODE_W-1:0]   mem [WORDS];
  logic [CODE_W-1:0]   mem_q;
  logic [CW-1:0]       fill [MAX_BITS];

  logic [PCW-1:0]      p, p_next;
  logic                found, found_next;
  logic [TW-1:0]       best, best_next;
  logic [CW-1:0]       cur_cnt, cur_cnt_next;
  logic [CODE_W-1:0]   origin, origin_next;
  logic [CW-1:0]       issue_pos, issue_pos_next;
  logic [CW-1:0]       chk_pos, chk_pos_next;
  logic                chk_vld, chk_vld_next;
  logic [START_W-1:0]  start, start_next;
  logic [TTIME_W-1:0]  res_ttime, res_ttime_next;
  logic                res_none, res_none_next;
  logic                res_diff, res_diff_next;

  logic                out_vld;
  logic [TTIME_W-1:0]  out_ttime, out_ttime_next;
  logic                out_none, out_none_next;
  logic                out_diff, out_diff_next;
  logic                out_drop, out_drop_next;
  logic                out_load;
  logic                out_free;

  logic [PCW-1:0]      n_planes;
  logic [PIW-1:0]      fill_idx;
  logic [CW-1:0]       fill_rd;
  logic                fill_full;
  logic                fill_we;
  logic [TW-1:0]       start_w;
  logic [TW-1:0]       cnt_w;
  logic                plane_last;
  logic                code_mism;
  logic                scan_mism;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [CODE_W-1:0]   mem_wd;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                cand_en;
  logic [TW-1:0]       cand_at;

  assign n_planes   = ({1'b0, bits_in_use} > 7'(MAX_BITS)) ? PCW'(MAX_BITS)
                                                            : PCW'(bits_in_use);
  assign fill_idx   = (state == ST_IDLE) ? PIW'(head.bit_index) : PIW'(p);
  assign fill_rd    = fill[fill_idx];
  assign fill_full  = fill_rd >= CW'(PLANE_DEPTH);
  assign start_w    = TW'(start);
  assign cnt_w      = TW'(fill_rd);
  assign plane_last = p == n_planes;
  assign code_mism  = mem_q != origin;
  assign scan_mism  = chk_vld && code_mism;
  assign out_free   = !out_vld || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && head.op == OP_FIND) begin
          state_next = ST_PLANE;
        end else if (q_valid && head.op == OP_COMPARE) begin
          state_next = ST_CPLANE;
        end
      end
      ST_PLANE: begin
        if (plane_last) begin
          state_next = ST_RESULT;
        end else if (cnt_w > start_w) begin
          state_next = ST_ORIGIN;
        end
      end
      ST_ORIGIN: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_mism || issue_pos == cur_cnt) begin
          state_next = ST_PLANE;
        end
      end
      ST_CPLANE: begin
        if (plane_last) begin
          state_next = ST_RESULT;
        end else if (cnt_w > start_w) begin
          state_next = ST_CPREV;
        end
      end
      ST_CPREV: state_next = ST_CCUR;
      ST_CCUR:  state_next = code_mism ? ST_RESULT : ST_CPLANE;
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = addr_of(fill_idx, DW'(fill_rd));
    mem_wd         = head.sample_value;
    fill_we        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = addr_of(PIW'(p), DW'(start_w));
    out_load       = 1'b0;
    out_ttime_next = res_ttime;
    out_none_next  = res_none;
    out_diff_next  = res_diff;
    out_drop_next  = 1'b0;
    p_next         = p;
    found_next     = found;
    best_next      = best;
    cur_cnt_next   = cur_cnt;
    origin_next    = origin;
    issue_pos_next = issue_pos;
    chk_pos_next   = chk_pos;
    chk_vld_next   = 1'b0;
    start_next     = start;
    res_ttime_next = res_ttime;
    res_none_next  = res_none;
    res_diff_next  = res_diff;
    cand_en        = 1'b0;
    cand_at        = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (head.op) inside
            OP_FIND, OP_COMPARE: begin
              pop        = 1'b1;
              start_next = head.start_time;
              p_next     = '0;
              found_next = 1'b0;
              best_next  = '0;
            end
            default: begin
              if (out_free) begin
                pop            = 1'b1;
                out_load       = 1'b1;
                out_ttime_next = '0;
                out_none_next  = 1'b0;
                out_diff_next  = 1'b0;
                out_drop_next  = (head.op == OP_DROP) ||
                                 (head.op == OP_APPEND && fill_full);
                if (head.op == OP_APPEND && !fill_full) begin
                  mem_we  = 1'b1;
                  fill_we = 1'b1;
                end
              end
            end
          endcase
        end
      end
      ST_PLANE: begin
        if (plane_last) begin
          res_ttime_next = found ? TTIME_W'(best) : '0;
          res_none_next  = !found;
          res_diff_next  = 1'b0;
        end else if (cnt_w == start_w) begin
          p_next = p + PCW'(1);
        end else if (start_w > cnt_w) begin
          // start past the fill: the plane reports the start itself
          cand_en = 1'b1;
          cand_at = start_w;
          p_next  = p + PCW'(1);
        end else begin
          rd_en          = 1'b1;
          cur_cnt_next   = fill_rd;
          issue_pos_next = CW'(start_w + TW'(1));
        end
      end
      ST_ORIGIN: begin
        origin_next = mem_q;
        if (issue_pos != cur_cnt) begin
          rd_en          = 1'b1;
          rd_addr        = addr_of(PIW'(p), DW'(issue_pos));
          chk_pos_next   = issue_pos;
          chk_vld_next   = 1'b1;
          issue_pos_next = issue_pos + CW'(1);
        end
      end
      ST_SCAN: begin
        if (scan_mism) begin
          cand_en = 1'b1;
          cand_at = TW'(chk_pos);
          p_next  = p + PCW'(1);
        end else if (issue_pos == cur_cnt) begin
          // no change up to the fill: the plane reports its count
          cand_en = 1'b1;
          cand_at = TW'(cur_cnt);
          p_next  = p + PCW'(1);
        end else begin
          rd_en          = 1'b1;
          rd_addr        = addr_of(PIW'(p), DW'(issue_pos));
          chk_pos_next   = issue_pos;
          chk_vld_next   = 1'b1;
          issue_pos_next = issue_pos + CW'(1);
        end
      end
      ST_CPLANE: begin
        if (plane_last) begin
          res_ttime_next = '0;
          res_none_next  = 1'b0;
          res_diff_next  = 1'b0;
        end else if (cnt_w > start_w) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(PIW'(p), DW'(start_w - TW'(1)));
        end else begin
          p_next = p + PCW'(1);
        end
      end
      ST_CPREV: begin
        origin_next = mem_q;
        rd_en       = 1'b1;
      end
      ST_CCUR: begin
        if (code_mism) begin
          res_ttime_next = '0;
          res_none_next  = 1'b0;
          res_diff_next  = 1'b1;
        end else begin
          p_next = p + PCW'(1);
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
    if (cand_en) begin
      found_next = 1'b1;
      if (!found || cand_at < best) begin
        best_next = cand_at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      out_vld <= 1'b0;
      for (int i = 0; i < MAX_BITS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      if (fill_we) begin
        fill[fill_idx] <= fill_rd + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p         <= p_next;
    found     <= found_next;
    best      <= best_next;
    cur_cnt   <= cur_cnt_next;
    origin    <= origin_next;
    issue_pos <= issue_pos_next;
    chk_pos   <= chk_pos_next;
    chk_vld   <= chk_vld_next;
    start     <= start_next;
    res_ttime <= res_ttime_next;
    res_none  <= res_none_next;
    res_diff  <= res_diff_next;
    if (out_load) begin
      out_ttime <= out_ttime_next;
      out_none  <= out_none_next;
      out_diff  <= out_diff_next;
      out_drop  <= out_drop_next;
    end
  end

  // sample store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign rsp.valid           = out_vld;
  assign rsp.transition_time = out_ttime;
  assign rsp.no_transition   = out_none;
  assign rsp.differs         = out_diff;
  assign rsp.full_drop       = out_drop;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> fill_rd < CW'(PLANE_DEPTH))
    else $error("append past plane depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (rd_en && (state == ST_SCAN || state == ST_ORIGIN)) |-> issue_pos < cur_cnt)
    else $error("scan reads beyond fill");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && q_valid))
    else $error("queue popped outside idle");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && !out_free) |=> (state == ST_RESULT && $stable(res_ttime)))
    else $error("pending result lost");

endmodule

// ----- rtl/core/waveform_capture_next_edge_search.sv -----
// ----------------------------------------------------------------------------
// waveform_capture_next_edge_search
// bit-plane capture store with append, next-transition search and compare
//
//   channel  dir  beat holds
//   req      in   command, bit_index, sample_value, start_time
//   rsp      out  transition_time, no_transition, differs, full_drop
//   cfg      in   bits_in_use write, no handshake
//
// appends, dropped appends and no-op commands are handled in idle, one per cycle
// sustained while rsp takes each result. a find pops and walks the planes in use
// on the single memory read port: a plane whose fill does not pass the start is
// passed over without a read, a scanned plane reads its sample at the start and
// then scans forward to the first change or to the fill, and the result is closed
// and loaded after the last plane. a compare pops, passes over each plane whose
// fill does not pass the start, reads the previous and current sample of the
// others, stops at the first difference and loads the result after it, or after
// the last plane when no plane differs. reset clears the fill counts; the sample
// memory is not cleared. a two-entry queue parts the front from the back and an
// output register holds the result while rsp stalls.
// ----------------------------------------------------------------------------
module waveform_capture_next_edge_search #(
  parameter int MAX_BITS    = 32,
  parameter int PLANE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [5:0]  cfg_write_data,
  wcs_req_if.sink     req,
  wcs_rsp_if.source   rsp
);
  import wcs_pkg::*;

  logic [BIU_W-1:0] bits_in_use;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  wcs_entry_t       push_entry;
  wcs_entry_t       head;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= BIU_W'(1);
    end else if (cfg_write_en) begin
      bits_in_use <= cfg_write_data;
    end
  end

  wcs_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  wcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  wcs_back #(
    .MAX_BITS    (MAX_BITS),
    .PLANE_DEPTH (PLANE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .bits_in_use (bits_in_use),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .rsp         (rsp)
  );

endmodule
